// ===== rtl/swdd_pkg.sv =====
// Shared types and constants for the split-window difference derivative filter.
package swdd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 17;
    localparam int CFG_W      = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic             REG_HALF_WINDOW = 1'b0;
    localparam logic [CFG_W-1:0] HALF_RESET      = 6'd4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [OUT_W-1:0]    t_deriv;

endpackage

// ===== rtl/swdd_if.sv =====
// Valid/ready stream interfaces for the sample input and derivative output.
interface swdd_sample_if import swdd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swdd_deriv_if import swdd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_deriv derivative;

    modport source (output valid, output derivative, input ready);
    modport sink   (input valid, input derivative, output ready);
endinterface

// ===== rtl/swdd_hist_mem.sv =====
// Sample history memory: one write port, two registered read ports.
module swdd_hist_mem import swdd_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_sample       i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output t_sample       o_rd_data_a,
    output t_sample       o_rd_data_b
);

    t_sample r_mem [DEPTH];
    t_sample r_rd_a;
    t_sample r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/swdd_div.sv =====
// Serial restoring divider: signed dividend by unsigned half window, truncating.
module swdd_div import swdd_pkg::*; #(
    parameter int DIFF_W = 22,
    parameter int HW     = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_dividend,
    input  logic [HW-1:0]            i_divisor,
    output logic                     o_done,
    output t_deriv                   o_quot
);

    localparam int CNT_W = $clog2(DIFF_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [HW-1:0]     r_rem;
    logic [DIFF_W-1:0] r_quo;

    logic [HW:0]       trial;
    logic              qbit;
    logic [DIFF_W-1:0] mag;
    logic [DIFF_W-1:0] signed_quo;

    always_comb begin
        mag   = i_dividend[DIFF_W-1] ? DIFF_W'(-i_dividend) : DIFF_W'(i_dividend);
        trial = {r_rem, r_quo[DIFF_W-1]};
        qbit  = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIFF_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag;
            r_neg <= i_dividend[DIFF_W-1];
        end else if (r_busy) begin
            r_rem <= qbit ? HW'(trial - {1'b0, i_divisor}) : HW'(trial);
            r_quo <= {r_quo[DIFF_W-2:0], qbit};
        end
    end

    assign signed_quo = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quot     = OUT_W'(signed_quo);
    assign o_done     = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < i_divisor))
        else $error("divider remainder out of range");

endmodule

// ===== rtl/split_window_difference_derivative_top.sv =====
// Top level of the split-window difference derivative filter.
//
//   channel       dir  handshake            payload
//   i_sample_ch   in   valid/ready          sample, 16-bit signed
//   o_deriv_ch    out  valid/ready          derivative, 17-bit signed
//   APB config    in   psel/penable/pwrite  half_window at byte address 0
//
// One transaction at a time. A sample that yields no result goes through a memory
// read, then update and write back. A sample that yields a result then enters the
// divide state, run by the one-bit-per-cycle divider, and then the output state.
// Reset is synchronous; no clearing pass, the fill count guards the history.
// A result waits in the output register while the next sample is taken.
module split_window_difference_derivative_top import swdd_pkg::*; #(
    parameter int MAX_HALF = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swdd_sample_if.sink           i_sample_ch,
    swdd_deriv_if.source          o_deriv_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH  = 2 * MAX_HALF;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW     = $clog2(MAX_HALF + 1);
    localparam int FILL_W = HW + 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_HALF);
    localparam int DIFF_W = SUM_W + 1;
    localparam int CMP_W  = (HW > CFG_W) ? HW : CFG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CFG_W-1:0]        r_half;
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic [PTR_W-1:0]        r_wp;
    logic [PTR_W-1:0]        n_wp;
    logic signed [SUM_W-1:0] r_older;
    logic signed [SUM_W-1:0] r_newer;
    logic signed [SUM_W-1:0] n_older;
    logic signed [SUM_W-1:0] n_newer;
    t_sample                 r_x;
    logic                    r_out_valid;
    t_deriv                  r_out_data;

    logic [CMP_W-1:0]         half_ext;
    logic [HW-1:0]            h;
    logic [FILL_W-1:0]        h_ext;
    logic [FILL_W-1:0]        full;
    logic [FILL_W-1:0]        mid_sum;
    logic [FILL_W-1:0]        mid;
    logic [FILL_W-1:0]        wp_inc;
    logic                     accept;
    logic                     cfg_wr;
    logic                     out_free;
    t_sample                  rd_old;
    t_sample                  rd_mid;
    logic signed [SUM_W-1:0]  drop_old;
    logic signed [SUM_W-1:0]  move_mid;
    logic signed [DIFF_W-1:0] diff;
    logic                     div_start;
    logic                     div_done;
    t_deriv                   div_quot;

    always_comb begin
        half_ext = CMP_W'(r_half);
        if (half_ext == '0) begin
            h = HW'(1);
        end else if (half_ext > CMP_W'(MAX_HALF)) begin
            h = HW'(MAX_HALF);
        end else begin
            h = HW'(half_ext);
        end
        h_ext   = FILL_W'(h);
        full    = {h, 1'b0};
        mid_sum = FILL_W'(r_wp) + h_ext;
        mid     = (mid_sum >= full) ? (mid_sum - full) : mid_sum;
        wp_inc  = FILL_W'(r_wp) + 1'b1;
    end

    assign accept   = i_sample_ch.valid && i_sample_ch.ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_HALF_WINDOW);
    assign out_free = !r_out_valid || o_deriv_ch.ready;

    swdd_hist_mem #(
        .DEPTH (DEPTH),
        .AW    (PTR_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (r_state == S_UPD),
        .i_wr_addr   (r_wp),
        .i_wr_data   (r_x),
        .i_rd_en     (accept),
        .i_rd_addr_a (r_wp),
        .i_rd_addr_b (PTR_W'(mid)),
        .o_rd_data_a (rd_old),
        .o_rd_data_b (rd_mid)
    );

    always_comb begin
        drop_old  = (r_fill >= full)  ? SUM_W'(rd_old) : '0;
        move_mid  = (r_fill >= h_ext) ? SUM_W'(rd_mid) : '0;
        n_older   = r_older - drop_old + move_mid;
        n_newer   = r_newer - move_mid + SUM_W'(r_x);
        diff      = DIFF_W'(n_newer) - DIFF_W'(n_older);
        n_wp      = (wp_inc >= full) ? '0 : PTR_W'(wp_inc);
        n_fill    = (r_fill < full) ? (r_fill + 1'b1) : r_fill;
        div_start = (r_state == S_UPD) && (n_fill >= full);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = div_start ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    swdd_div #(
        .DIFF_W (DIFF_W),
        .HW     (HW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff),
        .i_divisor  (h),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half      <= HALF_RESET;
            r_fill      <= '0;
            r_wp        <= '0;
            r_older     <= '0;
            r_newer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_half  <= pwdata[CFG_W-1:0];
                r_fill  <= '0;
                r_wp    <= '0;
                r_older <= '0;
                r_newer <= '0;
            end else if (r_state == S_UPD) begin
                r_fill  <= n_fill;
                r_wp    <= n_wp;
                r_older <= n_older;
                r_newer <= n_newer;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_deriv_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_sample_ch.sample;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data <= div_quot;
        end
    end

    assign i_sample_ch.ready     = (r_state == S_IDLE);
    assign o_deriv_ch.valid      = r_out_valid;
    assign o_deriv_ch.derivative = r_out_data;
    assign pready                = 1'b1;
    assign prdata = (paddr[2] == REG_HALF_WINDOW) ? APB_DATA_W'(r_half) : '0;

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_UPD))
        else $error("accepted sample not followed by update");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= full) && (FILL_W'(r_wp) < full))
        else $error("fill count or write pointer beyond window");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");
    a_start_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_fill == full))
        else $error("result started before window filled");

endmodule
